// File: hdl/bmsh_pkg.sv
// Shared types and constants for the battery monitor core.
// Holds the register map and reset defaults, the config, command and status structs, and datapath widths.
// No dependencies.
package bmsh_pkg;

   localparam int MV_W      = 16;
   localparam int RATIO_W   = 5;
   localparam int MARGIN_W  = 12;
   localparam int PCT_W     = 7;
   localparam int FACTOR_W  = 17;
   localparam int DIV_STEPS = 7;
   localparam int DIV_CNT_W = 3;
   localparam int NUM_W     = MV_W + PCT_W;
   localparam int DEN_SH_W  = MV_W + DIV_STEPS - 1;

   localparam int unsigned VREF_MV  = 3300;
   localparam int unsigned PCT_FULL = 100;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;

   localparam logic [IDX_W-1:0] REG_EMPTY_MV    = 3'd0;
   localparam logic [IDX_W-1:0] REG_WARN_MV     = 3'd1;
   localparam logic [IDX_W-1:0] REG_FULL_MV     = 3'd2;
   localparam logic [IDX_W-1:0] REG_DIV_RATIO   = 3'd3;
   localparam logic [IDX_W-1:0] REG_MARGIN_MV   = 3'd4;
   localparam logic [IDX_W-1:0] REG_INTERVAL    = 3'd5;

   localparam logic [MV_W-1:0]     RST_EMPTY_MV  = 16'd3300;
   localparam logic [MV_W-1:0]     RST_WARN_MV   = 16'd3500;
   localparam logic [MV_W-1:0]     RST_FULL_MV   = 16'd4200;
   localparam logic [RATIO_W-1:0]  RST_DIV_RATIO = 5'd3;
   localparam logic [MARGIN_W-1:0] RST_MARGIN_MV = 12'd200;
   localparam logic [MV_W-1:0]     RST_INTERVAL  = 16'd1000;

   typedef struct packed {
      logic [MV_W-1:0]     empty_mv;
      logic [MV_W-1:0]     warn_mv;
      logic [MV_W-1:0]     full_mv;
      logic [RATIO_W-1:0]  divider_ratio;
      logic [MARGIN_W-1:0] recover_margin_mv;
      logic [MV_W-1:0]     interval_ticks;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic calc_factor;
      logic calc_mv;
      logic update;
      logic pct_setup;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pct_clamped;
   } sts_type;

endpackage

// File: hdl/bmsh_regs.sv
// Configuration register file behind the APB-style port.
// Depends on bmsh_pkg for the register map and cfg_type.
module bmsh_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bmsh_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [bmsh_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [bmsh_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output bmsh_pkg::cfg_type             cfg
);

   localparam int DW = bmsh_pkg::DATA_W;

   bmsh_pkg::cfg_type cfg_ff, cfg_in;
   logic [bmsh_pkg::IDX_W-1:0] idx;
   logic wr;

   assign idx        = csr_paddr[bmsh_pkg::ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            bmsh_pkg::REG_EMPTY_MV:  cfg_in.empty_mv = csr_pwdata[bmsh_pkg::MV_W-1:0];
            bmsh_pkg::REG_WARN_MV:   cfg_in.warn_mv = csr_pwdata[bmsh_pkg::MV_W-1:0];
            bmsh_pkg::REG_FULL_MV:   cfg_in.full_mv = csr_pwdata[bmsh_pkg::MV_W-1:0];
            bmsh_pkg::REG_DIV_RATIO: cfg_in.divider_ratio = csr_pwdata[bmsh_pkg::RATIO_W-1:0];
            bmsh_pkg::REG_MARGIN_MV: begin
               cfg_in.recover_margin_mv = csr_pwdata[bmsh_pkg::MARGIN_W-1:0];
            end
            bmsh_pkg::REG_INTERVAL:  cfg_in.interval_ticks = csr_pwdata[bmsh_pkg::MV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         bmsh_pkg::REG_EMPTY_MV:  csr_prdata = DW'(cfg_ff.empty_mv);
         bmsh_pkg::REG_WARN_MV:   csr_prdata = DW'(cfg_ff.warn_mv);
         bmsh_pkg::REG_FULL_MV:   csr_prdata = DW'(cfg_ff.full_mv);
         bmsh_pkg::REG_DIV_RATIO: csr_prdata = DW'(cfg_ff.divider_ratio);
         bmsh_pkg::REG_MARGIN_MV: csr_prdata = DW'(cfg_ff.recover_margin_mv);
         bmsh_pkg::REG_INTERVAL:  csr_prdata = DW'(cfg_ff.interval_ticks);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.empty_mv          <= bmsh_pkg::RST_EMPTY_MV;
         cfg_ff.warn_mv           <= bmsh_pkg::RST_WARN_MV;
         cfg_ff.full_mv           <= bmsh_pkg::RST_FULL_MV;
         cfg_ff.divider_ratio     <= bmsh_pkg::RST_DIV_RATIO;
         cfg_ff.recover_margin_mv <= bmsh_pkg::RST_MARGIN_MV;
         cfg_ff.interval_ticks    <= bmsh_pkg::RST_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/bmsh_ctrl.sv
// Sequencing state machine for the battery monitor core.
// Issues datapath commands per transaction and owns both handshakes; depends on bmsh_pkg.
module bmsh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bmsh_pkg::sts_type sts,
   output bmsh_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FACTOR = 3'd1;
   localparam logic [2:0] ST_SCALE  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_PCT    = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   localparam logic [bmsh_pkg::DIV_CNT_W-1:0] DIV_LAST =
      bmsh_pkg::DIV_CNT_W'(bmsh_pkg::DIV_STEPS - 1);

   logic [2:0] state_ff, state_in;
   logic [bmsh_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_FACTOR;
            end
         end
         ST_FACTOR: begin
            cmd.calc_factor = 1'b1;
            state_in        = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.calc_mv = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PCT;
         end
         ST_PCT: begin
            cmd.pct_setup = 1'b1;
            div_cnt_in    = '0;
            state_in      = sts.pct_clamped ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_OUT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending transaction");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff <= DIV_LAST))
      else $error("divide step count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_FACTOR))
      else $error("accepted transaction did not start processing");

endmodule

// File: hdl/bmsh_datapath.sv
// Datapath: scaling, smoothing, hysteresis flags, iterative percent divide, result register.
// Driven by bmsh_ctrl commands; depends on bmsh_pkg.
module bmsh_datapath #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bmsh_pkg::cfg_type               cfg,
   input  bmsh_pkg::cmd_type               cmd,
   output bmsh_pkg::sts_type               sts,
   input  logic [SAMPLE_BITS-1:0]          req_adc_raw,
   output logic                            rsp_sampled,
   output logic [bmsh_pkg::MV_W-1:0]       rsp_smoothed_mv,
   output logic [bmsh_pkg::PCT_W-1:0]      rsp_percent,
   output logic                            rsp_low_battery,
   output logic                            rsp_rf_allowed,
   output logic                            rsp_rf_cut_now
);

   localparam int MV_W   = bmsh_pkg::MV_W;
   localparam int FW     = bmsh_pkg::FACTOR_W;
   localparam int PCT_W  = bmsh_pkg::PCT_W;
   localparam int NUM_W  = bmsh_pkg::NUM_W;
   localparam int DSH_W  = bmsh_pkg::DEN_SH_W;
   localparam int PROD_W = SAMPLE_BITS + FW;

   logic [SAMPLE_BITS-1:0] raw_ff;
   logic [FW-1:0]          factor_ff;
   logic [MV_W-1:0]        mv_ff;
   logic [MV_W-1:0]        smoothed_ff, smoothed_in;
   logic [MV_W-1:0]        tick_ff, tick_in;
   logic                   seeded_ff, seeded_in;
   logic                   low_ff, low_in;
   logic                   rf_cut_ff, rf_cut_in;
   logic                   sampled_ff, sampled_in;
   logic                   cut_now_ff, cut_now_in;
   logic [NUM_W-1:0]       rem_ff;
   logic [DSH_W-1:0]       den_sh_ff;
   logic [PCT_W-1:0]       pct_ff;

   logic                   rsp_sampled_ff, rsp_low_ff, rsp_rf_allowed_ff, rsp_cut_now_ff;
   logic [MV_W-1:0]        rsp_smoothed_ff;
   logic [PCT_W-1:0]       rsp_percent_ff;

   logic [PROD_W-1:0]      product;
   logic [FW-1:0]          scaled;
   logic [MV_W-1:0]        mv_sat;
   logic [MV_W+2:0]        ema_sum;
   logic [MV_W-1:0]        ema;
   logic [MV_W-1:0]        elapsed;
   logic [MV_W:0]          release_lvl;
   logic                   set_low, low_a, rf_a, clear_low;
   logic                   at_full, at_empty;
   logic [MV_W-1:0]        diff, den;
   logic                   rem_ge;

   assign product = PROD_W'(raw_ff) * PROD_W'(factor_ff);
   assign scaled  = product[PROD_W-1:SAMPLE_BITS];
   assign mv_sat  = (scaled[FW-1:MV_W] != '0) ? '1 : scaled[MV_W-1:0];

   assign ema_sum = {smoothed_ff, 3'b000} - (MV_W+3)'(smoothed_ff) + (MV_W+3)'(mv_ff);
   assign ema     = ema_sum[MV_W+2:3];
   assign elapsed = (&tick_ff) ? tick_ff : tick_ff + 1'b1;
   assign release_lvl = (MV_W+1)'(cfg.warn_mv) + (MV_W+1)'(cfg.recover_margin_mv);

   assign set_low   = (ema < cfg.empty_mv);
   assign low_a     = low_ff | set_low;
   assign rf_a      = rf_cut_ff | set_low;
   assign clear_low = low_a && ((MV_W+1)'(ema) > release_lvl);

   always_comb begin
      smoothed_in = smoothed_ff;
      tick_in     = tick_ff;
      seeded_in   = seeded_ff;
      low_in      = low_ff;
      rf_cut_in   = rf_cut_ff;
      sampled_in  = 1'b0;
      cut_now_in  = 1'b0;
      if (!seeded_ff) begin
         smoothed_in = mv_ff;
         tick_in     = '0;
         seeded_in   = 1'b1;
         sampled_in  = 1'b1;
      end else if (elapsed >= cfg.interval_ticks) begin
         tick_in     = '0;
         sampled_in  = 1'b1;
         smoothed_in = ema;
         cut_now_in  = set_low & ~rf_cut_ff;
         low_in      = low_a & ~clear_low;
         rf_cut_in   = rf_a & ~clear_low;
      end else begin
         tick_in = elapsed;
      end
   end

   assign at_full  = (smoothed_ff >= cfg.full_mv);
   assign at_empty = (smoothed_ff <= cfg.empty_mv);
   assign diff     = smoothed_ff - cfg.empty_mv;
   assign den      = cfg.full_mv - cfg.empty_mv;
   assign rem_ge   = (rem_ff >= NUM_W'(den_sh_ff));
   assign sts.pct_clamped = at_full | at_empty;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         raw_ff <= req_adc_raw;
      end
      if (cmd.calc_factor) begin
         factor_ff <= FW'(cfg.divider_ratio) * FW'(bmsh_pkg::VREF_MV);
      end
      if (cmd.calc_mv) begin
         mv_ff <= mv_sat;
      end
      if (cmd.pct_setup) begin
         rem_ff    <= NUM_W'(diff) * NUM_W'(bmsh_pkg::PCT_FULL);
         den_sh_ff <= DSH_W'(den) << (bmsh_pkg::DIV_STEPS - 1);
         pct_ff    <= at_full ? PCT_W'(bmsh_pkg::PCT_FULL) : '0;
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - NUM_W'(den_sh_ff);
         end
         den_sh_ff <= den_sh_ff >> 1;
         pct_ff    <= {pct_ff[PCT_W-2:0], rem_ge};
      end
      if (cmd.load_out) begin
         rsp_sampled_ff    <= sampled_ff;
         rsp_smoothed_ff   <= smoothed_ff;
         rsp_percent_ff    <= pct_ff;
         rsp_low_ff        <= low_ff;
         rsp_rf_allowed_ff <= ~rf_cut_ff;
         rsp_cut_now_ff    <= cut_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
         tick_ff     <= '0;
         seeded_ff   <= 1'b0;
         low_ff      <= 1'b0;
         rf_cut_ff   <= 1'b0;
         sampled_ff  <= 1'b0;
         cut_now_ff  <= 1'b0;
      end else if (cmd.update) begin
         smoothed_ff <= smoothed_in;
         tick_ff     <= tick_in;
         seeded_ff   <= seeded_in;
         low_ff      <= low_in;
         rf_cut_ff   <= rf_cut_in;
         sampled_ff  <= sampled_in;
         cut_now_ff  <= cut_now_in;
      end
   end

   assign rsp_sampled     = rsp_sampled_ff;
   assign rsp_smoothed_mv = rsp_smoothed_ff;
   assign rsp_percent     = rsp_percent_ff;
   assign rsp_low_battery = rsp_low_ff;
   assign rsp_rf_allowed  = rsp_rf_allowed_ff;
   assign rsp_rf_cut_now  = rsp_cut_now_ff;

   assert property (@(posedge clock) disable iff (reset)
      rf_cut_ff |-> low_ff)
      else $error("rf cut latched without low flag");

   assert property (@(posedge clock) disable iff (reset)
      !(&tick_ff))
      else $error("tick count held at saturation");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (pct_ff <= PCT_W'(bmsh_pkg::PCT_FULL)))
      else $error("percent above full scale");

   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> seeded_ff)
      else $error("update left the monitor unseeded");

endmodule

// File: hdl/battery_monitor_smooth_hysteresis_core.sv
// Battery monitor core: an accepted transaction passes the factor, scale, update, percent setup
// states, the 7-step restoring percent divide (skipped when the percent is clamped at 0 or 100)
// and the output state, which waits while a stalled result is pending, then loads the result
// register. One transaction at a time; the result register frees the input side.
// Reset is synchronous, active high: config registers reset to defaults and the monitor unseeds.
module battery_monitor_smooth_hysteresis_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [SAMPLE_BITS-1:0]          req_adc_raw,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_sampled,
   output logic [bmsh_pkg::MV_W-1:0]       rsp_smoothed_mv,
   output logic [bmsh_pkg::PCT_W-1:0]      rsp_percent,
   output logic                            rsp_low_battery,
   output logic                            rsp_rf_allowed,
   output logic                            rsp_rf_cut_now,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bmsh_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [bmsh_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [bmsh_pkg::DATA_W-1:0]     csr_prdata,
   output logic                            csr_pready
);

   bmsh_pkg::cfg_type cfg;
   bmsh_pkg::cmd_type cmd;
   bmsh_pkg::sts_type sts;

   bmsh_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bmsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bmsh_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_adc_raw     (req_adc_raw),
      .rsp_sampled     (rsp_sampled),
      .rsp_smoothed_mv (rsp_smoothed_mv),
      .rsp_percent     (rsp_percent),
      .rsp_low_battery (rsp_low_battery),
      .rsp_rf_allowed  (rsp_rf_allowed),
      .rsp_rf_cut_now  (rsp_rf_cut_now)
   );

endmodule

// File: tb/battery_monitor_smooth_hysteresis_core_tb.sv
// Self-checking testbench for the battery monitor core: one tick in, one report out.
// Predicts smoothing, sampling interval, low-battery hysteresis, RF cut and percent in place.
// Depends on bmsh_pkg and battery_monitor_smooth_hysteresis_core.
module battery_monitor_smooth_hysteresis_core_tb;

   localparam int SAMPLE_BITS = 12;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                         sampled;
      logic [bmsh_pkg::MV_W-1:0]    smoothed_mv;
      logic [bmsh_pkg::PCT_W-1:0]   percent;
      logic                         low_battery;
      logic                         rf_allowed;
      logic                         rf_cut_now;
   } battery_report_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [SAMPLE_BITS-1:0]        req_adc_raw = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_sampled;
   logic [bmsh_pkg::MV_W-1:0]     rsp_smoothed_mv;
   logic [bmsh_pkg::PCT_W-1:0]    rsp_percent;
   logic                          rsp_low_battery;
   logic                          rsp_rf_allowed;
   logic                          rsp_rf_cut_now;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [bmsh_pkg::ADDR_W-1:0]   csr_paddr = '0;
   logic [bmsh_pkg::DATA_W-1:0]   csr_pwdata = '0;
   logic [bmsh_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   logic [SAMPLE_BITS-1:0]        pending_ticks[$];
   battery_report_type            expected_reports[$];

   bmsh_pkg::cfg_type             settings = '{bmsh_pkg::RST_EMPTY_MV, bmsh_pkg::RST_WARN_MV,
                                               bmsh_pkg::RST_FULL_MV, bmsh_pkg::RST_DIV_RATIO,
                                               bmsh_pkg::RST_MARGIN_MV, bmsh_pkg::RST_INTERVAL};
   logic [bmsh_pkg::MV_W-1:0]     tick_cnt = '0;
   logic [bmsh_pkg::MV_W-1:0]     smooth_mv = '0;
   bit                            seeded = 1'b0;
   bit                            low_flag = 1'b0;
   bit                            rf_cut = 1'b0;

   int unsigned            send_idle_pct = 0;
   int unsigned            recv_stall_pct = 0;
   int unsigned            hold_requests = 0;
   int unsigned            hold_served = 0;
   int unsigned            hold_left = 0;

   int unsigned            failures = 0;
   int unsigned            reports_checked = 0;
   int unsigned            samples_seen = 0;
   int unsigned            low_seen = 0;
   int unsigned            cuts_seen = 0;
   int unsigned            settings_written = 0;

   battery_monitor_smooth_hysteresis_core #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_adc_raw(req_adc_raw),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sampled(rsp_sampled),
      .rsp_smoothed_mv(rsp_smoothed_mv), .rsp_percent(rsp_percent),
      .rsp_low_battery(rsp_low_battery), .rsp_rf_allowed(rsp_rf_allowed),
      .rsp_rf_cut_now(rsp_rf_cut_now),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   function automatic battery_report_type advance_monitor(input logic [SAMPLE_BITS-1:0] raw);
      longint unsigned    scaled;
      int unsigned        mv;
      int unsigned        elapsed;
      int unsigned        v;
      battery_report_type rpt;
      rpt = '0;
      scaled = (longint'(raw) * bmsh_pkg::VREF_MV * settings.divider_ratio) >> SAMPLE_BITS;
      mv = (scaled > 65535) ? 65535 : int'(scaled);
      if (!seeded) begin
         smooth_mv = mv[bmsh_pkg::MV_W-1:0];
         tick_cnt = '0;
         seeded = 1'b1;
         rpt.sampled = 1'b1;
      end else begin
         elapsed = tick_cnt + 1;
         if (elapsed > 65535) elapsed = 65535;
         if (elapsed >= settings.interval_ticks) begin
            tick_cnt = '0;
            rpt.sampled = 1'b1;
            v = (smooth_mv * 7 + mv) >> 3;
            smooth_mv = v[bmsh_pkg::MV_W-1:0];
            if (smooth_mv < settings.empty_mv) begin
               low_flag = 1'b1;
               if (!rf_cut) begin
                  rf_cut = 1'b1;
                  rpt.rf_cut_now = 1'b1;
               end
            end
            if (low_flag && int'(smooth_mv) >
                  int'(settings.warn_mv) + int'(settings.recover_margin_mv)) begin
               low_flag = 1'b0;
               rf_cut = 1'b0;
            end
         end else begin
            tick_cnt = elapsed[bmsh_pkg::MV_W-1:0];
         end
      end
      v = smooth_mv;
      if (v >= settings.full_mv) begin
         rpt.percent = bmsh_pkg::PCT_W'(bmsh_pkg::PCT_FULL);
      end else if (v <= settings.empty_mv) begin
         rpt.percent = '0;
      end else begin
         rpt.percent = bmsh_pkg::PCT_W'(((v - settings.empty_mv) * bmsh_pkg::PCT_FULL) /
                                        (settings.full_mv - settings.empty_mv));
      end
      rpt.smoothed_mv = smooth_mv;
      rpt.low_battery = low_flag;
      rpt.rf_allowed  = !rf_cut;
      return rpt;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_adc_raw <= pending_ticks.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_left   <= LONG_HOLD;
         hold_served <= hold_requests;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      battery_report_type got;
      battery_report_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_reports.push_back(advance_monitor(req_adc_raw));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_sampled, rsp_smoothed_mv, rsp_percent, rsp_low_battery,
                    rsp_rf_allowed, rsp_rf_cut_now};
            if (expected_reports.size() == 0) begin
               if (failures < MAX_REPORTS) $display("unexpected report at %0t", $realtime);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  if (failures < MAX_REPORTS) begin
                     $display("report %0d mismatch: expected sampled=%0d mv=%0d pct=%0d low=%0d rf=%0d cut=%0d",
                              reports_checked, want.sampled, want.smoothed_mv, want.percent,
                              want.low_battery, want.rf_allowed, want.rf_cut_now);
                     $display("   got sampled=%0d mv=%0d pct=%0d low=%0d rf=%0d cut=%0d",
                              got.sampled, got.smoothed_mv, got.percent,
                              got.low_battery, got.rf_allowed, got.rf_cut_now);
                  end
                  failures++;
               end
            end
            reports_checked++;
            samples_seen += got.sampled;
            low_seen     += got.low_battery;
            cuts_seen    += got.rf_cut_now;
         end
      end
   end

   task automatic csr_write(input logic [bmsh_pkg::IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         bmsh_pkg::REG_EMPTY_MV:  settings.empty_mv       = bmsh_pkg::MV_W'(value);
         bmsh_pkg::REG_WARN_MV:   settings.warn_mv        = bmsh_pkg::MV_W'(value);
         bmsh_pkg::REG_FULL_MV:   settings.full_mv        = bmsh_pkg::MV_W'(value);
         bmsh_pkg::REG_DIV_RATIO: settings.divider_ratio  = bmsh_pkg::RATIO_W'(value);
         bmsh_pkg::REG_MARGIN_MV: begin
            settings.recover_margin_mv = bmsh_pkg::MARGIN_W'(value);
         end
         bmsh_pkg::REG_INTERVAL:  settings.interval_ticks = bmsh_pkg::MV_W'(value);
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned empty_mv, warn_mv, full_mv, ratio,
                                 margin_mv, interval);
      csr_write(bmsh_pkg::REG_EMPTY_MV, empty_mv);
      csr_write(bmsh_pkg::REG_WARN_MV, warn_mv);
      csr_write(bmsh_pkg::REG_FULL_MV, full_mv);
      csr_write(bmsh_pkg::REG_DIV_RATIO, ratio);
      csr_write(bmsh_pkg::REG_MARGIN_MV, margin_mv);
      csr_write(bmsh_pkg::REG_INTERVAL, interval);
      settings_written++;
   endtask

   task automatic drain_reports();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_reports.size() != 0);
   endtask

   task automatic random_settings();
      int unsigned ratio;
      int unsigned span;
      int unsigned empty_mv;
      int unsigned full_mv;
      if ($urandom_range(3) == 0) begin
         apply_settings($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(31), $urandom_range(4095),
                        $urandom_range(1) ? $urandom_range(65535) : $urandom_range(4));
      end else begin
         ratio = $urandom_range(1, 16);
         span = bmsh_pkg::VREF_MV * ratio;
         empty_mv = $urandom_range(span / 4, span / 2);
         full_mv = empty_mv + $urandom_range(1, span / 2);
         apply_settings(empty_mv, empty_mv + $urandom_range(span / 8), full_mv, ratio,
                        $urandom_range(span / 16 > 4095 ? 4095 : span / 16),
                        ($urandom_range(7) == 0) ? $urandom_range(5, 20) : $urandom_range(3));
      end
   endtask

   initial begin
      int level;
      int delta;
      bit rising;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // seed tick, then ticks that fall short of the interval
      pending_ticks = '{12'hFFF, 12'h000, 12'd1500};
      drain_reports();
      // scaling saturates, flag sets and releases on every sample, full below empty
      apply_settings(65535, 0, 0, 31, 4095, 0);
      pending_ticks = '{12'h000, 12'hFFF, 12'hFFF, 12'h800, 12'h001};
      drain_reports();
      // zero divider drives the level further down, below empty
      apply_settings(40000, 45000, 50000, 0, 4095, 1);
      pending_ticks = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
      drain_reports();
      // recover above warn with no margin, percent inside the span
      apply_settings(3000, 20000, 60000, 16, 0, 2);
      pending_ticks = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h555, 12'hAAA, 12'h000};
      drain_reports();

      for (int phase = 0; phase < 10; phase++) begin
         send_idle_pct  = (phase < 4) ? 31 : (phase < 7) ? 50 : 0;
         recv_stall_pct = (phase < 4) ? 50 : (phase < 7) ? 31 : 0;
         random_settings();
         @(negedge clock);
         if (phase == 8) hold_requests <= hold_requests + 1;
         level = $urandom_range(4095);
         rising = $urandom_range(1);
         for (int n = 0; n < 48; n++) begin
            if ($urandom_range(9) == 0) begin
               pending_ticks.push_back(SAMPLE_BITS'($urandom_range(4095)));
            end else begin
               delta = $urandom_range(320);
               level = rising ? level + delta : level - delta;
               if (level > 4095) level = 4095;
               if (level < 0) level = 0;
               if ($urandom_range(11) == 0 || level == 0 || level == 4095) rising = !rising;
               pending_ticks.push_back(level[SAMPLE_BITS-1:0]);
            end
         end
         drain_reports();
      end

      repeat (20) @(posedge clock);
      if (expected_reports.size() != 0) failures++;
      $display("Checked %0d reports across %0d register settings,", reports_checked,
               settings_written);
      $display("three idling modes and a long hold at the output.");
      $display("Saw %0d samples, %0d low-battery reports and %0d RF cut pulses.",
               samples_seen, low_seen, cuts_seen);
      if (failures == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: battery_monitor_smooth_hysteresis_core.f
hdl/bmsh_pkg.sv
hdl/bmsh_regs.sv
hdl/bmsh_ctrl.sv
hdl/bmsh_datapath.sv
hdl/battery_monitor_smooth_hysteresis_core.sv
tb/battery_monitor_smooth_hysteresis_core_tb.sv
